/* design/page_bitmap_allocator_unit_defines.svh */
// assertion macros for the page bitmap allocator
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page bitmap allocator check failed");
`else
`define PBA_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`ifndef SYNTH
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page bitmap allocator check failed");
`else
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/pba_pkg.sv */
// shared types, constants and helper functions of the page bitmap allocator
package pba_pkg;

   localparam int PAGES_DEFAULT = 4096;
   localparam int WORD_BITS     = 64;
   localparam int OFF_BITS      = 6;
   localparam int START_W       = 12;
   localparam int LEN_W         = 13;
   localparam int COUNT_W       = 13;
   localparam int LIMIT_W       = 13;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   localparam logic [1:0] KIND_FREE  = 2'd0;
   localparam logic [1:0] KIND_ALLOC = 2'd1;
   localparam logic [1:0] KIND_GET   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH,
      ST_PASS_RD,
      ST_PASS_WR,
      ST_DONE
   } pba_state_type;

   // {found, index of lowest set bit}
   function automatic logic [OFF_BITS:0] lowest_one(input logic [WORD_BITS-1:0] v);
      logic [OFF_BITS:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, OFF_BITS'(i)};
         end
      end
      return r;
   endfunction

   function automatic logic [OFF_BITS:0] pop_count(input logic [WORD_BITS-1:0] v);
      logic [OFF_BITS:0] c;
      c = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         c = c + (OFF_BITS + 1)'(v[i]);
      end
      return c;
   endfunction

endpackage

/* design/page_bitmap_allocator_unit.sv */
// Page bitmap allocator: one free bit per page (1 = free) kept in a 64-bit wide map memory,
// plus a free page count. Requests are free run, allocate at page and first-fit get; each
// request gives one result beat. After reset a clearing pass writes the map to all used,
// one word a cycle, and no request is taken until it ends. The map memory has one port
// pair and every word is read into a register before it is used: a free or a take reads
// and then writes back each map word of the run; a get or an allocate check reads each
// word it enters and then searches it on one shared priority encoder, and a get searches
// a word once more for each start of a free stretch and for each end of a free stretch
// below the word's top page that it meets there; a successful get or allocate then runs
// the take pass over the granted run. Requests that touch no map word (failed allocate or
// get range checks, zero lengths, unknown kinds) go from the accepting cycle straight to a
// done state that loads the result. One request is in work at a time; a finished result
// waits in the output register while the next request enters, and a request that finishes
// while that register is still full waits for it.
`include "page_bitmap_allocator_unit_defines.svh"

module page_bitmap_allocator_unit #(
   parameter int PAGES = pba_pkg::PAGES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request beat
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // start_page[11:0], run_length[24:12]
   input  logic [1:0]                        req_tuser,  // kind[1:0]
   // result beat
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // ok[0], granted_page[12:1],
                                                         // free_pages[25:13]
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pba_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pba_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pba_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int WB    = pba_pkg::WORD_BITS;
   localparam int OB    = pba_pkg::OFF_BITS;
   localparam int WORDS = (PAGES + WB - 1) / WB;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PW    = ($clog2(PAGES + 1) > 14) ? $clog2(PAGES + 1) : 14;
   localparam logic [PW-1:0]  PAGES_P   = PW'(PAGES);
   localparam logic [PW-1:0]  WB_P      = PW'(WB);
   localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

   // ---------------- registers ----------------
   pba_pkg::pba_state_type state_ff, state_in;

   logic [1:0]                       kind_ff, kind_in;
   logic [pba_pkg::START_W-1:0]      grant_ff, grant_in;
   logic [PW-1:0]                    len_ff, len_in;
   logic [PW-1:0]                    ptr_ff, ptr_in;
   logic [PW-1:0]                    end_ff, end_in;
   logic [PW-1:0]                    run_ff, run_in;
   logic                             seek_ff, seek_in;   // 1: looking for a free page
   logic                             set_ff, set_in;     // 1: pass frees, 0: pass takes
   logic                             ok_ff, ok_in;
   logic [PW-1:0]                    cnt_ff, cnt_in;
   logic [pba_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic [WAW-1:0]                   clr_ptr_ff, clr_ptr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_ok_ff, rsp_ok_in;
   logic [pba_pkg::START_W-1:0]      rsp_grant_ff, rsp_grant_in;
   logic [pba_pkg::COUNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;
   logic [WB-1:0]                    rd_data_ff;

   logic [WB-1:0]                    map_mem [WORDS];

   // ---------------- memory controls ----------------
   logic                             mem_re;
   logic                             mem_we;
   logic [WAW-1:0]                   mem_rd_addr;
   logic [WAW-1:0]                   mem_wr_addr;
   logic [WB-1:0]                    mem_wr_data;

   // ---------------- shared unit ----------------
   logic [PW-1:0]       lim;
   logic [PW-1:0]       wbase;
   logic [PW-1:0]       wend;
   logic [OB-1:0]       off;
   logic [WB-1:0]       lo_mask;
   logic [WB-1:0]       cand;
   logic [OB:0]         enc;
   logic                found;
   logic [PW-1:0]       hit;
   logic [PW-1:0]       stop;
   logic [PW-1:0]       endp;
   logic [PW-1:0]       nhi;
   logic [WB-1:0]       hi_mask;
   logic [WB-1:0]       pass_mask;
   logic [WB-1:0]       pass_word;
   logic [OB:0]         newly;
   logic                pass_last;

   // search outcome
   logic                srch_ok;
   logic                srch_fail;
   logic                srch_next;
   logic [PW-1:0]       srch_ptr;
   logic [PW-1:0]       srch_run;
   logic                srch_seek;

   // request decode
   logic [PW-1:0]       q_start;
   logic [PW-1:0]       q_len;
   logic [PW-1:0]       q_end;
   logic [PW-1:0]       q_fend;
   logic                accept;
   logic                go_pass;
   logic                go_srch;
   logic                q_ok;
   logic                out_load;
   logic                csr_wr;

   // assertion terms
   logic                in_srch;
   logic                take_wr;
   logic                take_all_free;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'b0)
                       ? pba_pkg::CSR_DATA_W'(limit_ff) : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_cnt_ff, rsp_grant_ff, rsp_ok_ff};

   assign lim = (PW'(limit_ff) < PAGES_P) ? PW'(limit_ff) : PAGES_P;

   // ---------------- shared search / mask unit ----------------
   always_comb begin
      off      = ptr_ff[OB-1:0];
      wbase    = {ptr_ff[PW-1:OB], {OB{1'b0}}};
      wend     = wbase + WB_P;
      lo_mask  = {WB{1'b1}} << off;
      cand     = (seek_ff ? rd_data_ff : ~rd_data_ff) & lo_mask;
      enc      = pba_pkg::lowest_one(cand);
      found    = enc[OB];
      hit      = wbase + PW'(enc[OB-1:0]);
      stop     = found ? hit : wend;
      endp     = (stop < lim) ? stop : lim;

      nhi       = end_ff - wbase;
      hi_mask   = (nhi >= WB_P) ? {WB{1'b1}} : ~({WB{1'b1}} << nhi[OB-1:0]);
      pass_mask = lo_mask & hi_mask;
      pass_word = set_ff ? (rd_data_ff | pass_mask) : (rd_data_ff & ~pass_mask);
      newly     = pba_pkg::pop_count(pass_mask & ~rd_data_ff);
      pass_last = (wend >= end_ff);

      srch_ok   = 1'b0;
      srch_fail = 1'b0;
      srch_next = 1'b0;
      srch_ptr  = ptr_ff;
      srch_run  = run_ff;
      srch_seek = seek_ff;
      if (!seek_ff) begin
         // inside a free stretch that began at run_ff
         priority if ((endp - run_ff) >= len_ff) begin
            srch_ok = 1'b1;
         end else if (found && (hit < lim)) begin
            if (kind_ff == pba_pkg::KIND_ALLOC) begin
               srch_fail = 1'b1;
            end else if (hit[OB-1:0] == {OB{1'b1}}) begin
               // used page closes the word: continue in the next one
               srch_seek = 1'b1;
               srch_ptr  = wend;
               srch_fail = (wend >= lim);
               srch_next = (wend < lim);
            end else begin
               srch_seek = 1'b1;
               srch_ptr  = hit + PW'(1);
            end
         end else if (stop >= lim) begin
            srch_fail = 1'b1;
         end else begin
            srch_ptr  = wend;
            srch_next = 1'b1;
         end
      end else begin
         // looking for the next free page
         priority if (found && (hit < lim)) begin
            srch_seek = 1'b0;
            srch_run  = hit;
            srch_ptr  = hit;
         end else if (found || (wend >= lim)) begin
            srch_fail = 1'b1;
         end else begin
            srch_ptr  = wend;
            srch_next = 1'b1;
         end
      end
   end

   // ---------------- request decode ----------------
   always_comb begin
      q_start = PW'(req_tdata[11:0]);
      q_len   = PW'(req_tdata[24:12]);
      q_end   = q_start + q_len;
      q_fend  = (q_end < PAGES_P) ? q_end : PAGES_P;
      accept  = req_tvalid && req_tready;
      go_pass = 1'b0;
      go_srch = 1'b0;
      q_ok    = 1'b0;
      unique case (req_tuser)
         pba_pkg::KIND_FREE: begin
            q_ok    = (q_len == '0) || (q_end <= PAGES_P);
            go_pass = (q_start < q_fend);
         end
         pba_pkg::KIND_ALLOC: begin
            if ((q_start <= lim) && (q_len <= (lim - q_start))) begin
               q_ok    = (q_len == '0);
               go_srch = (q_len != '0);
            end
         end
         pba_pkg::KIND_GET: begin
            if (q_start < lim) begin
               q_ok    = (q_len == '0);
               go_srch = (q_len != '0);
            end
         end
         default: begin
            q_ok = 1'b0;
         end
      endcase
      out_load = !rsp_valid_ff || rsp_tready;
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pba_pkg::ST_CLEAR: begin
            if (clr_ptr_ff == LAST_WORD) begin
               state_in = pba_pkg::ST_IDLE;
            end
         end
         pba_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (go_pass) begin
                  state_in = pba_pkg::ST_PASS_RD;
               end else if (go_srch) begin
                  state_in = pba_pkg::ST_SRCH_RD;
               end else begin
                  state_in = pba_pkg::ST_DONE;
               end
            end
         end
         pba_pkg::ST_SRCH_RD: begin
            state_in = pba_pkg::ST_SRCH;
         end
         pba_pkg::ST_SRCH: begin
            priority if (srch_ok) begin
               state_in = pba_pkg::ST_PASS_RD;
            end else if (srch_fail) begin
               state_in = pba_pkg::ST_DONE;
            end else if (srch_next) begin
               state_in = pba_pkg::ST_SRCH_RD;
            end else begin
               state_in = pba_pkg::ST_SRCH;
            end
         end
         pba_pkg::ST_PASS_RD: begin
            state_in = pba_pkg::ST_PASS_WR;
         end
         pba_pkg::ST_PASS_WR: begin
            state_in = pass_last ? pba_pkg::ST_DONE : pba_pkg::ST_PASS_RD;
         end
         pba_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = pba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pba_pkg::ST_CLEAR;
         end
      endcase
   end

   // ---------------- outputs and memory controls ----------------
   always_comb begin
      req_tready  = 1'b0;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      mem_rd_addr = ptr_ff[WAW+OB-1:OB];
      mem_wr_addr = ptr_ff[WAW+OB-1:OB];
      mem_wr_data = pass_word;
      unique case (state_ff)
         pba_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wr_addr = clr_ptr_ff;
            mem_wr_data = '0;
         end
         pba_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         pba_pkg::ST_SRCH_RD, pba_pkg::ST_PASS_RD: begin
            mem_re = 1'b1;
         end
         pba_pkg::ST_PASS_WR: begin
            mem_we = 1'b1;
         end
         pba_pkg::ST_SRCH, pba_pkg::ST_DONE: begin
            mem_re = 1'b0;
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      kind_in      = kind_ff;
      grant_in     = grant_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      run_in       = run_ff;
      seek_in      = seek_ff;
      set_in       = set_ff;
      ok_in        = ok_ff;
      cnt_in       = cnt_ff;
      clr_ptr_in   = clr_ptr_ff;
      limit_in     = csr_wr && (csr_paddr[2] == 1'b0)
                     ? csr_pwdata[pba_pkg::LIMIT_W-1:0] : limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      unique case (state_ff)
         pba_pkg::ST_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + WAW'(1);
         end
         pba_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in  = req_tuser;
               grant_in = req_tdata[11:0];
               len_in   = q_len;
               ok_in    = q_ok;
               ptr_in   = q_start;
               run_in   = q_start;
               end_in   = q_fend;
               seek_in  = (req_tuser == pba_pkg::KIND_GET);
               set_in   = (req_tuser == pba_pkg::KIND_FREE);
            end
         end
         pba_pkg::ST_SRCH: begin
            if (srch_ok) begin
               ok_in    = 1'b1;
               grant_in = run_ff[pba_pkg::START_W-1:0];
               ptr_in   = run_ff;
               end_in   = run_ff + len_ff;
               set_in   = 1'b0;
               cnt_in   = cnt_ff - len_ff;
            end else begin
               ptr_in  = srch_ptr;
               run_in  = srch_run;
               seek_in = srch_seek;
            end
         end
         pba_pkg::ST_PASS_WR: begin
            ptr_in = wend;
            if (set_ff) begin
               cnt_in = cnt_ff + PW'(newly);
            end
         end
         pba_pkg::ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_grant_in = grant_ff;
               rsp_cnt_in   = cnt_ff[pba_pkg::COUNT_W-1:0];
            end
         end
         pba_pkg::ST_SRCH_RD, pba_pkg::ST_PASS_RD: begin
            ptr_in = ptr_ff;
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pba_pkg::ST_CLEAR;
         clr_ptr_ff   <= '0;
         cnt_ff       <= '0;
         limit_ff     <= pba_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      grant_ff     <= grant_in;
      len_ff       <= len_in;
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      run_ff       <= run_in;
      seek_ff      <= seek_in;
      set_ff       <= set_in;
      ok_ff        <= ok_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   // map memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_rd_addr];
      end
   end

   // ---------------- assertions ----------------
   assign in_srch       = (state_ff == pba_pkg::ST_SRCH);
   assign take_wr       = (state_ff == pba_pkg::ST_PASS_WR) && !set_ff;
   assign take_all_free = ((rd_data_ff & pass_mask) == pass_mask);

   `PBA_ASSERT_IMPL(a_count_in_range, clock, reset, 1'b1, cnt_ff <= PAGES_P)
   `PBA_ASSERT_IMPL(a_run_behind_cursor, clock, reset, in_srch, run_ff <= ptr_ff)
   `PBA_ASSERT_IMPL(a_take_only_free, clock, reset, take_wr, take_all_free)
   `PBA_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

/* tb/page_bitmap_allocator_unit_test.sv */
// self-checking testbench for the page bitmap allocator: directed, limit sweep and random traffic
module page_bitmap_allocator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 20;
   localparam int MAP_PAGES      = 4096;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [pba_pkg::CSR_ADDR_W-1:0] ADDR_PAGE_LIMIT = '0;

   typedef struct packed {
      logic [pba_pkg::COUNT_W-1:0] free_pages;
      logic [pba_pkg::START_W-1:0] granted;
      logic                        ok;
   } result_beat_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [31:0]                    req_tdata = '0;   // start_page[11:0], run_length[24:12]
   logic [1:0]                     req_tuser = '0;   // kind[1:0]
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [31:0]                    rsp_tdata;  // ok[0], granted_page[12:1], free_pages[25:13]
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [pba_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [pba_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [pba_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // shadow of the allocator state
   bit page_free [0:MAP_PAGES-1];
   int free_total = 0;
   int page_limit_cfg = 4096;

   result_beat_type pending_results[$];
   int bad_beats = 0;
   int idle_cycles = 0;
   bit in_burst = 1'b0;
   int burst_left = 0;
   int ready_pct = 100;
   int pattern_left = 0;

   page_bitmap_allocator_unit #(.PAGES(MAP_PAGES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void note_bad_beat(input string what);
      bad_beats++;
      if (bad_beats <= 10) $display("%0t: %s", $time, what);
   endfunction

   function automatic void take_pages(input int first, input int count);
      for (int p = first; p < first + count; p++) page_free[p] = 1'b0;
      free_total -= count;
   endfunction

   function automatic result_beat_type predict_request(input logic [1:0] kind,
         input logic [pba_pkg::START_W-1:0] start, input logic [pba_pkg::LEN_W-1:0] len);
      result_beat_type r;
      int lim, s, n, p, run;
      lim = (page_limit_cfg < MAP_PAGES) ? page_limit_cfg : MAP_PAGES;
      s = start;
      n = len;
      r.ok = 1'b0;
      r.granted = start;
      case (kind)
         pba_pkg::KIND_FREE: begin
            r.ok = 1'b1;
            for (p = s; p < s + n; p++) begin
               // pages past the map are dropped and flagged
               if (p >= MAP_PAGES) begin
                  r.ok = 1'b0;
                  break;
               end
               if (!page_free[p]) begin
                  page_free[p] = 1'b1;
                  free_total++;
               end
            end
         end
         pba_pkg::KIND_ALLOC: begin
            if (s <= lim && n <= lim - s) begin
               r.ok = 1'b1;
               for (p = s; p < s + n; p++) if (!page_free[p]) r.ok = 1'b0;
               if (r.ok) take_pages(s, n);
            end
         end
         pba_pkg::KIND_GET: begin
            if (s < lim) begin
               if (n == 0) begin
                  r.ok = 1'b1;
               end else begin
                  run = 0;
                  for (p = s; p < lim && !r.ok; p++) begin
                     if (page_free[p]) run++;
                     else run = 0;
                     if (run == n) begin
                        r.granted = pba_pkg::START_W'(p + 1 - n);
                        take_pages(p + 1 - n, n);
                        r.ok = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      r.free_pages = pba_pkg::COUNT_W'(free_total);
      return r;
   endfunction

   // one request beat; valid stays up across a burst
   task automatic send_request(input logic [1:0] kind, input int start, input int len);
      if (!in_burst) begin
         repeat ($urandom_range(0, 2) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 6))
            @(negedge clock);
         burst_left = $urandom_range(1, 24);
         in_burst = 1'b1;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, pba_pkg::LEN_W'(len), pba_pkg::START_W'(start)};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_request(kind, pba_pkg::START_W'(start),
                                                pba_pkg::LEN_W'(len)));
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         in_burst = 1'b0;
      end
   endtask

   task automatic drain_results();
      if (in_burst) begin
         req_tvalid <= 1'b0;
         in_burst = 1'b0;
         burst_left = 0;
      end
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // write the limit register, then read it back
   task automatic set_page_limit(input int value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_PAGE_LIMIT;
      csr_pwdata  <= pba_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      page_limit_cfg = value & 'h1FFF;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== pba_pkg::CSR_DATA_W'(page_limit_cfg))
         note_bad_beat($sformatf("page_limit read: expected %0d, got %0d",
                                 page_limit_cfg, csr_prdata));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic int random_run_length();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 3) return 0;
      if (sel < 70) return $urandom_range(1, 16);
      if (sel < 92) return $urandom_range(17, 256);
      if (sel < 98) return $urandom_range(257, 4095);
      return 4096;
   endfunction

   function automatic int free_page_hint();
      int p;
      p = 0;
      for (int tries = 0; tries < 16; tries++) begin
         p = $urandom_range(0, MAP_PAGES - 1);
         if (page_free[p]) return p;
      end
      return p;
   endfunction

   // mix leans toward frees when the map runs dry and toward takes when it fills
   task automatic send_random_request();
      int sel, free_pct, start, len;
      logic [1:0] kind;
      free_pct = (free_total < 1024) ? 55 : (free_total > 3000) ? 20 : 35;
      sel = $urandom_range(0, 99);
      len = random_run_length();
      if (sel < free_pct) begin
         kind = pba_pkg::KIND_FREE;
         start = ($urandom_range(0, 9) == 0) ? MAP_PAGES - $urandom_range(1, 64)
                                             : $urandom_range(0, MAP_PAGES - 1);
      end else if (sel < free_pct + 30) begin
         kind = pba_pkg::KIND_ALLOC;
         start = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAP_PAGES - 1)
                                             : free_page_hint();
      end else if (sel < 98) begin
         kind = pba_pkg::KIND_GET;
         start = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAP_PAGES - 1);
      end else begin
         kind = KIND_UNKNOWN;
         start = $urandom_range(0, MAP_PAGES - 1);
      end
      send_request(kind, start, len);
   endtask

   task automatic test_directed_cases();
      send_request(pba_pkg::KIND_GET, 0, 1);            // empty map, no fit
      send_request(pba_pkg::KIND_ALLOC, 0, 1);          // page still used
      send_request(pba_pkg::KIND_FREE, 0, 0);
      send_request(pba_pkg::KIND_ALLOC, 4095, 0);
      send_request(pba_pkg::KIND_GET, 4095, 0);
      send_request(pba_pkg::KIND_FREE, 0, 4096);
      send_request(pba_pkg::KIND_FREE, 4095, 4096);     // runs past the map
      send_request(pba_pkg::KIND_ALLOC, 16, 16);
      send_request(pba_pkg::KIND_GET, 0, 32);           // first fit lands above the hole
      send_request(pba_pkg::KIND_GET, 4095, 1);
      send_request(pba_pkg::KIND_ALLOC, 4094, 2);
      send_request(KIND_UNKNOWN, 4095, 4096);
      send_request(pba_pkg::KIND_FREE, 0, 4096);
      send_request(pba_pkg::KIND_GET, 0, 4096);
      send_request(pba_pkg::KIND_FREE, 2048, 2048);
   endtask

   task automatic test_limit_sweep();
      int limits[6];
      int lim;
      limits = '{0, 1, 4095, 2048, 0, 4096};
      limits[4] = $urandom_range(64, 4000);
      foreach (limits[i]) begin
         drain_results();
         set_page_limit(limits[i]);
         lim = limits[i];
         // runs that straddle the limit
         send_request(pba_pkg::KIND_ALLOC, (lim == 0) ? 0 : lim - 1, 2);
         send_request(pba_pkg::KIND_GET, (lim > 4095) ? 4095 : lim, 1);
         repeat (100) send_random_request();
      end
   endtask

   task automatic test_random_traffic();
      drain_results();
      set_page_limit(4096);
      repeat (1000) send_random_request();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_limit_sweep();
      test_random_traffic();
      drain_results();
      repeat (200) @(negedge clock);
      if (bad_beats == 0 && pending_results.size() == 0)
         $display("page_bitmap_allocator_unit: match");
      else
         $display("page_bitmap_allocator_unit: mismatch");
      $finish;
   end

   // result-side backpressure in phases of different ready density
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
         endcase
         pattern_left = $urandom_range(20, 300);
      end
      pattern_left--;
      rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
   end

   always @(posedge clock) begin : check_results
      result_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[25:0];
         if (pending_results.size() == 0) begin
            note_bad_beat($sformatf("result beat with nothing pending: ok=%0d page=%0d free=%0d",
                                    got.ok, got.granted, got.free_pages));
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok || got.granted !== want.granted ||
                got.free_pages !== want.free_pages)
               note_bad_beat($sformatf(
                  "result: expected ok=%0d page=%0d free=%0d, got ok=%0d page=%0d free=%0d",
                  want.ok, want.granted, want.free_pages,
                  got.ok, got.granted, got.free_pages));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("page_bitmap_allocator_unit: mismatch");
         $finish;
      end
   end

endmodule
